[hdl/fkc_pkg.sv]
// ---------------------------------------------------------------------------
// fkc_pkg
// shared types, constants and the cordic arctangent table for the
// forward kinematics chain
// ---------------------------------------------------------------------------
package fkc_pkg;

  // default parameter values
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // angle constants, Q4.28 radians
  localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;

  // cordic set-up, Q2.30 gain compensation
  localparam int                 CORDIC_STEPS     = 28;
  localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032874;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_TRIG_T = 3'd2,
    OP_TRIG_A = 3'd3,
    OP_LINK   = 3'd4,
    OP_MAC    = 3'd5,
    OP_COMMIT = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       start;
    logic [2:0] sel;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] kk;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_busy;
    logic last;
  } status_t;

  // arctangent of 2^-i in Q4.28
  function automatic logic signed [33:0] fkc_atan(input logic [4:0] i);
    logic signed [33:0] t;
    case (i)
      5'd0:    t = 34'sd210828714;
      5'd1:    t = 34'sd124459457;
      5'd2:    t = 34'sd65760959;
      5'd3:    t = 34'sd33381290;
      5'd4:    t = 34'sd16755422;
      5'd5:    t = 34'sd8385879;
      5'd6:    t = 34'sd4193963;
      5'd7:    t = 34'sd2097109;
      5'd8:    t = 34'sd1048571;
      5'd9:    t = 34'sd524287;
      default: t = 34'sd1 <<< (5'd28 - i);
    endcase
    return t;
  endfunction

endpackage

[hdl/fkc_cordic.sv]
// ---------------------------------------------------------------------------
// fkc_cordic
// iterative sine and cosine: range reduction by repeated add or subtract of
// two pi, quadrant fold, then one rotation-mode cordic step per cycle
// ---------------------------------------------------------------------------
module fkc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] angle,
  output logic               done,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import fkc_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_REDUCE = 4'b0010,
    C_FOLD   = 4'b0100,
    C_ITER   = 4'b1000
  } cstate_t;

  cstate_t            state_r, state_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic signed [33:0] dx, dy, at, r_fold;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    dx        = y_r >>> i_r;
    dy        = x_r >>> i_r;
    at        = fkc_atan(i_r);
    r_fold    = (z_r >= PI_Q) ? z_r - TWO_PI_Q : z_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          z_nxt     = 34'(angle);
          state_nxt = C_REDUCE;
        end
      end
      // bring the angle into zero to two pi
      C_REDUCE: begin
        if (z_r < 0) begin
          z_nxt = z_r + TWO_PI_Q;
        end else if (z_r >= TWO_PI_Q) begin
          z_nxt = z_r - TWO_PI_Q;
        end else begin
          state_nxt = C_FOLD;
        end
      end
      // fold into plus or minus half pi, remember the sign flip
      C_FOLD: begin
        neg_nxt = 1'b0;
        z_nxt   = r_fold;
        if (r_fold > HALF_PI_Q) begin
          z_nxt   = r_fold - PI_Q;
          neg_nxt = 1'b1;
        end else if (r_fold < -HALF_PI_Q) begin
          z_nxt   = r_fold + PI_Q;
          neg_nxt = 1'b1;
        end
        x_nxt     = CORDIC_GAIN_INIT;
        y_nxt     = '0;
        i_nxt     = '0;
        state_nxt = C_ITER;
      end
      // one micro-rotation per cycle
      C_ITER: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          if (neg_r) begin
            x_nxt = -x_nxt;
            y_nxt = -y_nxt;
          end
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    neg_r <= neg_nxt;
  end

  assign done  = done_r;
  assign cos_o = x_r[31:0];
  assign sin_o = y_r[31:0];

endmodule

[hdl/fkc_dp.sv]
// ---------------------------------------------------------------------------
// fkc_dp
// datapath: joint capture, shared cordic, link matrix and running product
// on one shared multiplier, result row buffer
// ---------------------------------------------------------------------------
module fkc_dp #(
  parameter int DATA_WIDTH = fkc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fkc_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fkc_pkg::cmd_t         cmd,
  output fkc_pkg::status_t      status,
  input  logic signed [31:0]    link_length,
  input  logic signed [31:0]    link_twist,
  input  logic signed [31:0]    link_offset,
  input  logic signed [31:0]    angle_offset,
  input  logic                  is_revolute,
  input  logic signed [31:0]    joint_value,
  input  logic                  last_joint,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            row_index,
  output logic [127:0]          row_data,
  output logic                  last_row
);
  import fkc_pkg::*;

  localparam int SW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int TF = 30 - FRAC_BITS;
  localparam int PF = 60 - FRAC_BITS;
  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (SW - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
    return (s == 0) ? v : ((v + (66'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return t[31:0];
  endfunction

  localparam logic signed [31:0] ONE_Q = sat(66'sd1 <<< FRAC_BITS);

  // joint registers
  logic signed [32:0] theta_r, alpha_r;
  logic signed [31:0] a_r;
  logic               last_r;
  logic signed [31:0] ct_r, st_r, ca_r, sa_r;
  logic signed [31:0] lk_r [0:11];
  logic signed [31:0] tm_r [0:11];
  logic signed [31:0] nt_r [0:11];

  // multiplier pipeline
  cmd_t               c1_r, c2_r;
  logic signed [31:0] opa_r, opb_r, opa_d_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, term, acc_sum, lterm;

  // row buffer
  logic [127:0]       ob_r [0:2];
  logic [1:0]         ob_ptr_r;
  logic               ob_busy_r;

  logic               cdone;
  logic signed [31:0] ccos, csin;

  fkc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .angle ((cmd.op == OP_TRIG_A) ? alpha_r : theta_r),
    .done  (cdone),
    .cos_o (ccos),
    .sin_o (csin)
  );

  // third stage arithmetic
  always_comb begin
    term    = rnd(66'(prod_r), FRAC_BITS);
    if (c2_r.kk == 2'd3) begin
      term = (c2_r.col == 2'd3) ? 66'(opa_d_r) : '0;
    end
    acc_sum = ((c2_r.kk == 2'd0) ? 66'sd0 : acc_r) + term;
    case (c2_r.sel)
      3'd2, 3'd5: lterm = rnd(66'(prod_r), 30);
      3'd0, 3'd4: lterm = -rnd(66'(prod_r), PF);
      default:    lterm = rnd(66'(prod_r), PF);
    endcase
  end

  // joint capture, trig results, operand select and multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else begin
      c1_r <= cmd;
      c2_r <= c1_r;
    end
    if (cmd.op == OP_LOAD) begin
      theta_r <= 33'(angle_offset) + (is_revolute ? 33'(joint_value) : 33'sd0);
      alpha_r <= 33'(link_twist);
      a_r     <= link_length;
      last_r  <= last_joint;
      lk_r[8] <= '0;
      lk_r[11] <= sat(66'(link_offset) + (is_revolute ? 66'sd0 : 66'(joint_value)));
    end
    if (cdone && cmd.op == OP_TRIG_T) begin
      ct_r    <= ccos;
      st_r    <= csin;
      lk_r[0] <= sat(rnd(66'(ccos), TF));
      lk_r[4] <= sat(rnd(66'(csin), TF));
    end
    if (cdone && cmd.op == OP_TRIG_A) begin
      ca_r     <= ccos;
      sa_r     <= csin;
      lk_r[9]  <= sat(rnd(66'(csin), TF));
      lk_r[10] <= sat(rnd(66'(ccos), TF));
    end
    // operand stage
    if (cmd.op == OP_LINK) begin
      case (cmd.sel)
        3'd0:    begin opa_r <= st_r; opb_r <= ca_r; end
        3'd1:    begin opa_r <= st_r; opb_r <= sa_r; end
        3'd2:    begin opa_r <= a_r;  opb_r <= ct_r; end
        3'd3:    begin opa_r <= ct_r; opb_r <= ca_r; end
        3'd4:    begin opa_r <= ct_r; opb_r <= sa_r; end
        default: begin opa_r <= a_r;  opb_r <= st_r; end
      endcase
    end else begin
      opa_r <= tm_r[{cmd.row, cmd.kk}];
      opb_r <= (cmd.kk == 2'd3) ? 32'sd0 : lk_r[{cmd.kk, cmd.col}];
    end
    // product stage
    prod_r  <= opa_r * opb_r;
    opa_d_r <= opa_r;
    // accumulate or write link entry
    if (c2_r.op == OP_MAC) begin
      acc_r <= acc_sum;
      if (c2_r.kk == 2'd3) begin
        nt_r[{c2_r.row, c2_r.col}] <= sat(acc_sum);
      end
    end
    if (c2_r.op == OP_LINK) begin
      case (c2_r.sel)
        3'd0:    lk_r[1] <= sat(lterm);
        3'd1:    lk_r[2] <= sat(lterm);
        3'd2:    lk_r[3] <= sat(lterm);
        3'd3:    lk_r[5] <= sat(lterm);
        3'd4:    lk_r[6] <= sat(lterm);
        default: lk_r[7] <= sat(lterm);
      endcase
    end
  end

  // running transform and row buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 12; k++) begin
        tm_r[k] <= (k == 0 || k == 5 || k == 10) ? ONE_Q : 32'sd0;
      end
      ob_busy_r <= 1'b0;
      ob_ptr_r  <= '0;
    end else begin
      if (cmd.op == OP_COMMIT) begin
        for (int k = 0; k < 12; k++) begin
          if (last_r) begin
            tm_r[k] <= (k == 0 || k == 5 || k == 10) ? ONE_Q : 32'sd0;
          end else begin
            tm_r[k] <= nt_r[k];
          end
        end
      end
      // a last-joint commit only happens with the buffer empty
      if (cmd.op == OP_COMMIT && last_r) begin
        ob_busy_r <= 1'b1;
        ob_ptr_r  <= '0;
      end else if (ob_busy_r && out_ready) begin
        if (ob_ptr_r == 2'd2) begin
          ob_busy_r <= 1'b0;
          ob_ptr_r  <= '0;
        end else begin
          ob_ptr_r <= ob_ptr_r + 2'd1;
        end
      end
    end
    if (cmd.op == OP_COMMIT && last_r) begin
      for (int r = 0; r < 3; r++) begin
        ob_r[r] <= {nt_r[r*4+3], nt_r[r*4+2], nt_r[r*4+1], nt_r[r*4]};
      end
    end
  end

  assign status.cordic_done = cdone;
  assign status.out_busy    = ob_busy_r;
  assign status.last        = last_r;

  assign out_valid = ob_busy_r;
  assign row_index = ob_ptr_r;
  assign row_data  = ob_r[ob_ptr_r];
  assign last_row  = (ob_ptr_r == 2'd2);

endmodule

[hdl/fkc_ctrl.sv]
// ---------------------------------------------------------------------------
// fkc_ctrl
// sequencer: accepts a joint, runs both cordic passes, issues the link
// products and the running product multiplies, then commits
// ---------------------------------------------------------------------------
module fkc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fkc_pkg::status_t status,
  output fkc_pkg::cmd_t    cmd
);
  import fkc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TSTART = 9'b000000010,
    S_TWAIT  = 9'b000000100,
    S_ASTART = 9'b000001000,
    S_AWAIT  = 9'b000010000,
    S_LINK   = 9'b000100000,
    S_MAC    = 9'b001000000,
    S_DRAIN  = 9'b010000000,
    S_COMMIT = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt, kk_r, kk_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    kk_nxt    = kk_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.op    = OP_NOP;
    cmd.sel   = cnt_r;
    cmd.row   = row_r;
    cmd.col   = col_r;
    cmd.kk    = kk_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.op    = OP_TRIG_T;
        cmd.start = 1'b1;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        cmd.op = OP_TRIG_T;
        if (status.cordic_done) state_nxt = S_ASTART;
      end
      S_ASTART: begin
        cmd.op    = OP_TRIG_A;
        cmd.start = 1'b1;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        cmd.op = OP_TRIG_A;
        if (status.cordic_done) begin
          cnt_nxt   = '0;
          state_nxt = S_LINK;
        end
      end
      // six link products
      S_LINK: begin
        cmd.op = OP_LINK;
        if (cnt_r == 3'd5) begin
          row_nxt   = '0;
          col_nxt   = '0;
          kk_nxt    = '0;
          state_nxt = S_MAC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      // row, column, term walk over the running product
      S_MAC: begin
        cmd.op = OP_MAC;
        kk_nxt = kk_r + 2'd1;
        if (kk_r == 2'd3) begin
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) begin
            row_nxt = row_r + 2'd1;
            if (row_r == 2'd2) begin
              cnt_nxt   = '0;
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      // let the multiplier pipeline empty
      S_DRAIN: begin
        if (cnt_r == 3'd1) begin
          state_nxt = S_COMMIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_COMMIT: begin
        if (!(status.last && status.out_busy)) begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      kk_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      kk_r    <= kk_nxt;
    end
  end

endmodule

[hdl/dh_forward_kinematics_chain.sv]
// ---------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg forward kinematics over a chain of joints, fixed point
// ---------------------------------------------------------------------------
// One joint transaction is taken at a time and runs through two passes of
// the shared iterative CORDIC (angle reduction, a fold step and 28 rotation
// steps each), then issue on the single shared 32x32 multiplier (6 link
// products, 48 running product slots) and a pipeline drain and commit. On
// the last joint the three rows of the end-effector transform go to a row
// buffer and the running transform returns to identity; the rows leave at
// one per cycle while out_tready is high, while the next chain already
// computes. Lengths and entries are Q16.16 by default, angles Q4.28
// radians, and all entries saturate.
// ---------------------------------------------------------------------------
module dh_forward_kinematics_chain #(
  parameter int DATA_WIDTH = fkc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fkc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // link_length, link_twist, link_offset, angle_offset, joint_value
  input  logic [159:0] in_tdata,
  // is_revolute
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_col0, entry_col1, entry_col2, entry_col3
  output logic [127:0] out_tdata,
  // row_index
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import fkc_pkg::*;

  cmd_t    cmd;
  status_t status;

  fkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fkc_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .link_length  (in_tdata[31:0]),
    .link_twist   (in_tdata[63:32]),
    .link_offset  (in_tdata[95:64]),
    .angle_offset (in_tdata[127:96]),
    .is_revolute  (in_tuser),
    .joint_value  (in_tdata[159:128]),
    .last_joint   (in_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .row_index    (out_tuser),
    .row_data     (out_tdata),
    .last_row     (out_tlast)
  );

endmodule

[hdl/fkc_checker.sv]
// ---------------------------------------------------------------------------
// fkc_checker
// port-level checks on the joint and result channels
// ---------------------------------------------------------------------------
module fkc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // a joint is worked on alone
  a_one_joint: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("joint accepted while previous joint still in work");

  // rows run 0, 1, 2 and tlast marks row 2
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 2'd2)) && (out_tuser != 2'd3))
    else $error("row index and tlast disagree");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tuser == $past(out_tuser) + 2'd1))
    else $error("result rows out of order");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result transaction changed");

endmodule

bind dh_forward_kinematics_chain fkc_checker u_fkc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[sim/dh_forward_kinematics_chain_test.sv]
// ---------------------------------------------------------------------------
// dh_forward_kinematics_chain_test
// self-checking bench for the DH forward kinematics chain: joint
// transactions are driven from a queue, a bit-true fixed point predictor
// builds the expected end-effector rows and a monitor checks every row
// transaction against them under random sender and receiver stalls
// ---------------------------------------------------------------------------
module dh_forward_kinematics_chain_test;
  import fkc_pkg::*;

  typedef struct {
    logic [31:0] link_length;
    logic [31:0] link_twist;
    logic [31:0] link_offset;
    logic [31:0] angle_offset;
    logic        is_revolute;
    logic [31:0] joint_value;
    logic        last_joint;
  } joint_t;

  typedef struct {
    logic [1:0]  row_index;
    logic [31:0] entry[4];
    logic        last_row;
  } row_t;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int MAX_CYCLE = 1500000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  joint_t       joint_q[$];
  row_t         row_q[$];
  longint       pose[12];
  int           fail_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_send;

  dh_forward_kinematics_chain dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // round half up, arithmetic shift
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 210828714;
      1: return 124459457;
      2: return 65760959;
      3: return 33381290;
      4: return 16755422;
      5: return 8385879;
      6: return 4193963;
      7: return 2097109;
      8: return 1048571;
      9: return 524287;
      default: return longint'(1) << (28 - i);
    endcase
  endfunction

  // cordic sine and cosine in Q2.30 after quadrant folding
  task automatic trig_q30(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = ang % longint'(TWO_PI_Q);
    flip = 0;
    if (r < 0) r += longint'(TWO_PI_Q);
    if (r >= longint'(PI_Q)) r -= longint'(TWO_PI_Q);
    if (r > longint'(HALF_PI_Q)) begin
      r -= longint'(PI_Q);
      flip = 1;
    end else if (r < -longint'(HALF_PI_Q)) begin
      r += longint'(PI_Q);
      flip = 1;
    end
    x = longint'(CORDIC_GAIN_INIT);
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic pose_identity();
    foreach (pose[k]) pose[k] = 0;
    for (int k = 0; k < 3; k++) pose[k * 4 + k] = longint'(1) << FB;
  endtask

  // fold one joint into the running pose, queue rows on the last joint
  task automatic predict_joint(input joint_t j);
    longint a, d, th, al, ct, st, ca, sa, acc;
    longint lk[12];
    longint nx[12];
    row_t   rw;
    a  = longint'($signed(j.link_length));
    d  = longint'($signed(j.link_offset));
    th = longint'($signed(j.angle_offset));
    al = longint'($signed(j.link_twist));
    if (j.is_revolute) th += longint'($signed(j.joint_value));
    else d += longint'($signed(j.joint_value));
    trig_q30(th, ct, st);
    trig_q30(al, ca, sa);
    lk[0]  = clamp32(round_shift(ct, 30 - FB));
    lk[1]  = clamp32(-round_shift(st * ca, 60 - FB));
    lk[2]  = clamp32(round_shift(st * sa, 60 - FB));
    lk[3]  = clamp32(round_shift(a * ct, 30));
    lk[4]  = clamp32(round_shift(st, 30 - FB));
    lk[5]  = clamp32(round_shift(ct * ca, 60 - FB));
    lk[6]  = clamp32(-round_shift(ct * sa, 60 - FB));
    lk[7]  = clamp32(round_shift(a * st, 30));
    lk[8]  = 0;
    lk[9]  = clamp32(round_shift(sa, 30 - FB));
    lk[10] = clamp32(round_shift(ca, 30 - FB));
    lk[11] = clamp32(d);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += round_shift(pose[r * 4 + k] * lk[k * 4 + c], FB);
        if (c == 3) acc += pose[r * 4 + 3];
        nx[r * 4 + c] = clamp32(acc);
      end
    pose = nx;
    if (j.last_joint) begin
      for (int r = 0; r < 3; r++) begin
        rw.row_index = r[1:0];
        for (int c = 0; c < 4; c++) rw.entry[c] = pose[r * 4 + c][31:0];
        rw.last_row = (r == 2);
        row_q.push_back(rw);
      end
      pose_identity();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // random angle: mostly near the principal range, sometimes anywhere
  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1686629713)) - 843314857);
      2: return $urandom_range(0, 1) ? 32'sd421657428 : -32'sd421657428;
      default: return 32'($signed($urandom_range(0, 1686629713)) - 843314857);
    endcase
  endfunction

  // random length: mostly moderate so that poses stay unsaturated
  function automatic logic [31:0] rand_length();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  task automatic push_joint(input logic [31:0] a, al, d, th, input logic rev,
                            input logic [31:0] q, input logic lst);
    joint_t j;
    j.link_length = a;
    j.link_twist = al;
    j.link_offset = d;
    j.angle_offset = th;
    j.is_revolute = rev;
    j.joint_value = q;
    j.last_joint = lst;
    joint_q.push_back(j);
  endtask

  // driver: sender side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_joint(joint_q.pop_front());
      if (joint_q.size() != 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {joint_q[0].joint_value, joint_q[0].angle_offset,
                      joint_q[0].link_offset, joint_q[0].link_twist,
                      joint_q[0].link_length};
        in_tuser  <= joint_q[0].is_revolute;
        in_tlast  <= joint_q[0].last_joint;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: receiver side and row checks
  always @(posedge clk) begin
    row_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (row_q.size() == 0) begin
        report_mismatch("unexpected row", 32'(out_tuser), 32'd0);
      end else begin
        want = row_q.pop_front();
        if (out_tuser !== want.row_index)
          report_mismatch("row_index", 32'(out_tuser), 32'(want.row_index));
        for (int c = 0; c < 4; c++)
          if (out_tdata[c * 32 +: 32] !== want.entry[c])
            report_mismatch($sformatf("row %0d col %0d", want.row_index, c),
                            out_tdata[c * 32 +: 32], want.entry[c]);
        if (out_tlast !== want.last_row)
          report_mismatch("last_row", 32'(out_tlast), 32'(want.last_row));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n_joint;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 66;
    hold_send = 0;
    pose_identity();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero chain, extremes, both joint kinds, single-joint chains
    push_joint(0, 0, 0, 0, 1, 0, 1);
    push_joint(32'h0001_0000, 32'sd421657428, 32'h0002_0000, 0, 1, 32'sd210828714, 0);
    push_joint(32'h0001_0000, 0, 0, 32'sd843314857, 0, 32'h0001_8000, 1);
    push_joint(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1,
               32'h7fff_ffff, 1);
    push_joint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
               32'h8000_0000, 1);
    push_joint(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1,
               32'hffff_ffff, 0);
    push_joint(32'h7fff_ffff, 32'sd843314857, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 1);
    push_joint(32'h0003_0000, -32'sd421657429, 0, -32'sd843314857, 1,
               -32'sd843314857, 0);
    push_joint(32'h0003_0000, 32'sd1686629713, 32'h0001_0000, 32'sd421657429, 1,
               32'sd1686629713, 0);
    push_joint(32'h0000_8000, -32'sd1686629713, -32'sh0001_0000, 0, 0,
               -32'sh0002_0000, 1);
    for (int i = 0; i < 6; i++) push_joint(32'h0001_0000, 32'sd421657428, 0,
                                            32'sd421657428, 1, 0, i == 5);

    // random chains of one to six joints, with some full-range noise joints
    n_joint = 0;
    while (n_joint < 400) begin
      int len;
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_joint($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                     $urandom, i == len - 1);
        else begin
          logic rev;
          rev = $urandom_range(0, 1);
          push_joint(rand_length(), rand_angle(), rand_length(), rand_angle(), rev,
                     rev ? rand_angle() : rand_length(), i == len - 1);
        end
      end
      n_joint += len;
      if (n_joint > 130 && send_idle_pct == 24 && joint_q.size() > 130) begin
        // phase switch is handled below once the first share has gone
      end
    end

    // idling phases, switched as the queue drains
    wait (joint_q.size() < 290);
    hold_send = 1;
    wait (row_q.size() == 0 && !in_tvalid);
    hold_send = 0;
    send_idle_pct = 66;
    recv_idle_pct = 24;
    wait (joint_q.size() < 140);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait (joint_q.size() == 0 && !in_tvalid);
    wait (row_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
